// File: rtl/euler_conserved_to_primitive_macros.svh
// Assertion macros for the checker of the conversion block.
`ifndef EULER_CONSERVED_TO_PRIMITIVE_MACROS_SVH
`define EULER_CONSERVED_TO_PRIMITIVE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ECP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ecp assertion failed");

// Clocked assertion that also holds during reset.
`define ECP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ecp assertion failed");

`endif

// File: rtl/ecp_pkg.sv
`default_nettype none

package ecp_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned Gm1W    = 18;
  localparam int unsigned FloorW  = 31;
  localparam int unsigned CfgIdxW = 2;

  // One quotient bit per divider stage, plus an entry and a saturation stage.
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivLat   = DivSteps + 2;
  // Input register, divider, then square, sum, kinetic product, difference,
  // pressure product and output register.
  localparam int unsigned PipeLat  = 1 + DivLat + 6;

  localparam logic [Gm1W-1:0]   Gm1Reset       = 18'd43691;
  localparam logic [FloorW-1:0] DensFloorReset = 31'd66;
  localparam logic [FloorW-1:0] PresFloorReset = 31'd66;
  localparam logic [40:0]       KeCap          = 41'h100_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAMMA_M1   = 2'd0,
    CFG_DENS_FLOOR = 2'd1,
    CFG_PRES_FLOOR = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/euler_conserved_to_primitive.sv
`default_nettype none

// Conserved-to-primitive conversion of one grid cell per transfer.
// Input channel s_axis_*: one cell's conserved state (density, three momenta,
// total energy, Q16.16) per transfer. Output channel m_axis_*: the primitive
// state (floored density, three velocities, floored pressure, error flag).
// Configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i
// (gamma minus one, density floor, pressure floor); write only while idle.
// Most of the pipeline between an input transfer and its result on the output
// is the velocity dividers, one quotient bit per divider step.
// Throughput is one cell per clock unless a result is stalled. All stages move
// together: the pipeline advances whenever the output register is empty or its
// result is taken, so s_axis_tready follows m_axis_tready while a result waits,
// and items in flight hold their place during a stall without loss or repetition.
// Reset clears all valid bits and loads the register defaults.
module euler_conserved_to_primitive (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // cons_density[31:0], mom_x[63:32], mom_y[95:64], mom_z[127:96],
  // total_energy[159:128]
  input  wire  [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // prim_density[30:0], vel_x[62:31], vel_y[94:63], vel_z[126:95],
  // gas_pressure[157:127], density_error[158], zero[159]
  output logic [159:0] m_axis_tdata,
  input  wire                            cfg_we_i,
  input  wire  [ecp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [ecp_pkg::FloorW-1:0]     cfg_data_i
);
  import ecp_pkg::*;

  // Configuration registers.
  logic [Gm1W-1:0]   gm1_q;
  logic [FloorW-1:0] dens_floor_q, pres_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gm1_q        <= Gm1Reset;
      dens_floor_q <= DensFloorReset;
      pres_floor_q <= PresFloorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GAMMA_M1:   gm1_q        <= cfg_data_i[Gm1W-1:0];
        CFG_DENS_FLOOR: dens_floor_q <= cfg_data_i;
        CFG_PRES_FLOOR: pres_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished result is stalled.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [PipeLat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[PipeLat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[PipeLat-1];

  // Stage A: split the input; density <= 0 takes the density floor, or one if zero.
  logic signed [WordW-1:0] rho_in, e_in;
  assign rho_in = $signed(s_axis_tdata[31:0]);
  assign e_in   = $signed(s_axis_tdata[159:128]);

  logic [FloorW-1:0]       rho_a_q;
  logic                    err_a_q;
  logic signed [WordW-1:0] mx_a_q, my_a_q, mz_a_q, e_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rho_in <= 0) begin
        rho_a_q <= (dens_floor_q == '0) ? FloorW'(1) : dens_floor_q;
        err_a_q <= 1'b1;
      end else begin
        rho_a_q <= rho_in[FloorW-1:0];
        err_a_q <= 1'b0;
      end
      mx_a_q <= $signed(s_axis_tdata[63:32]);
      my_a_q <= $signed(s_axis_tdata[95:64]);
      mz_a_q <= $signed(s_axis_tdata[127:96]);
      e_a_q  <= e_in;
    end
  end

  // Velocities: three dividers in lockstep.
  logic signed [WordW-1:0] vx, vy, vz;
  ecp_div u_div_x (.clk_i, .en_i(en), .num_i(mx_a_q), .den_i(rho_a_q), .quo_o(vx));
  ecp_div u_div_y (.clk_i, .en_i(en), .num_i(my_a_q), .den_i(rho_a_q), .quo_o(vy));
  ecp_div u_div_z (.clk_i, .en_i(en), .num_i(mz_a_q), .den_i(rho_a_q), .quo_o(vz));

  // Side data rides alongside the dividers.
  logic [FloorW-1:0]       rho_dl_q [DivLat];
  logic                    err_dl_q [DivLat];
  logic signed [WordW-1:0] e_dl_q   [DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rho_dl_q[0] <= rho_a_q;
      err_dl_q[0] <= err_a_q;
      e_dl_q[0]   <= e_a_q;
      for (int i = 1; i < DivLat; i++) begin
        rho_dl_q[i] <= rho_dl_q[i-1];
        err_dl_q[i] <= err_dl_q[i-1];
        e_dl_q[i]   <= e_dl_q[i-1];
      end
    end
  end

  // Stage B: squared velocity magnitudes.
  logic [WordW-1:0] magx, magy, magz;
  assign magx = vx[WordW-1] ? WordW'(-vx) : WordW'(vx);
  assign magy = vy[WordW-1] ? WordW'(-vy) : WordW'(vy);
  assign magz = vz[WordW-1] ? WordW'(-vz) : WordW'(vz);

  logic [63:0]             sqx_b_q, sqy_b_q, sqz_b_q;
  logic signed [WordW-1:0] vx_b_q, vy_b_q, vz_b_q, e_b_q;
  logic [FloorW-1:0]       rho_b_q;
  logic                    err_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_b_q <= magx * magx;
      sqy_b_q <= magy * magy;
      sqz_b_q <= magz * magz;
      vx_b_q  <= vx;
      vy_b_q  <= vy;
      vz_b_q  <= vz;
      e_b_q   <= e_dl_q[DivLat-1];
      rho_b_q <= rho_dl_q[DivLat-1];
      err_b_q <= err_dl_q[DivLat-1];
    end
  end

  // Stage C: speed squared, Q32.32; three terms of at most 2^62 cannot overflow.
  logic [63:0]             sum_c_q;
  logic signed [WordW-1:0] vx_c_q, vy_c_q, vz_c_q, e_c_q;
  logic [FloorW-1:0]       rho_c_q;
  logic                    err_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_c_q <= sqx_b_q + sqy_b_q + sqz_b_q;
      vx_c_q  <= vx_b_q;
      vy_c_q  <= vy_b_q;
      vz_c_q  <= vz_b_q;
      e_c_q   <= e_b_q;
      rho_c_q <= rho_b_q;
      err_c_q <= err_b_q;
    end
  end

  // Stage D: density times speed squared as two 31x32 partial products.
  logic [62:0]             ka_d_q, kb_d_q;
  logic signed [WordW-1:0] vx_d_q, vy_d_q, vz_d_q, e_d_q;
  logic [FloorW-1:0]       rho_d_q;
  logic                    err_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ka_d_q  <= rho_c_q * sum_c_q[63:32];
      kb_d_q  <= rho_c_q * sum_c_q[31:0];
      vx_d_q  <= vx_c_q;
      vy_d_q  <= vy_c_q;
      vz_d_q  <= vz_c_q;
      e_d_q   <= e_c_q;
      rho_d_q <= rho_c_q;
      err_d_q <= err_c_q;
    end
  end

  // Stage E: kinetic energy (halved, capped) and energy minus it.
  logic [63:0]        kin_sum;
  logic [40:0]        ke;
  logic signed [41:0] diff;
  assign kin_sum = {1'b0, ka_d_q} + {33'b0, kb_d_q[62:32]};
  assign ke      = (kin_sum[63:1] > {22'b0, KeCap}) ? KeCap : kin_sum[41:1];
  assign diff    = $signed({{10{e_d_q[WordW-1]}}, e_d_q}) - $signed({1'b0, ke});

  logic                    dpos_e_q;
  logic [FloorW-1:0]       dmag_e_q;
  logic signed [WordW-1:0] vx_e_q, vy_e_q, vz_e_q;
  logic [FloorW-1:0]       rho_e_q;
  logic                    err_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dpos_e_q <= !diff[41] && (diff != '0);
      dmag_e_q <= diff[FloorW-1:0];
      vx_e_q   <= vx_d_q;
      vy_e_q   <= vy_d_q;
      vz_e_q   <= vz_d_q;
      rho_e_q  <= rho_d_q;
      err_e_q  <= err_d_q;
    end
  end

  // Stage F: gamma minus one times the positive difference.
  logic [Gm1W+FloorW-1:0]  pm_f_q;
  logic                    dpos_f_q;
  logic signed [WordW-1:0] vx_f_q, vy_f_q, vz_f_q;
  logic [FloorW-1:0]       rho_f_q;
  logic                    err_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_f_q   <= gm1_q * dmag_e_q;
      dpos_f_q <= dpos_e_q;
      vx_f_q   <= vx_e_q;
      vy_f_q   <= vy_e_q;
      vz_f_q   <= vz_e_q;
      rho_f_q  <= rho_e_q;
      err_f_q  <= err_e_q;
    end
  end

  // Stage G: scale, saturate, apply the pressure floor, output register.
  logic [Gm1W+FloorW-FracW-1:0] pscaled;
  logic [FloorW-1:0]            pres;
  assign pscaled = pm_f_q[Gm1W+FloorW-1:FracW];

  always_comb begin
    if (!dpos_f_q)                          pres = '0;
    else if (pscaled > 33'h0_7FFF_FFFF)     pres = 31'h7FFF_FFFF;
    else                                    pres = pscaled[FloorW-1:0];
    if (pres == '0) pres = pres_floor_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {1'b0, err_f_q, pres, vz_f_q, vy_f_q, vx_f_q, rho_f_q};
    end
  end

endmodule

`default_nettype wire

// File: rtl/ecp_div.sv
`default_nettype none

// Pipelined saturating Q16.16 divider: one restoring step per stage.
module ecp_div (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire  signed [ecp_pkg::WordW-1:0]  num_i,
  input  wire         [ecp_pkg::FloorW-1:0] den_i,
  output logic signed [ecp_pkg::WordW-1:0]  quo_o
);
  import ecp_pkg::*;

  logic              neg_q  [DivSteps+1];
  logic              ovf_q  [DivSteps+1];
  logic [FloorW-1:0] den_q  [DivSteps+1];
  logic [FloorW-1:0] rem_q  [DivSteps+1];
  logic [WordW-1:0]  bits_q [DivSteps+1];
  logic [WordW-1:0]  quo_q  [DivSteps+1];

  logic [WordW-1:0] mag;
  assign mag = num_i[WordW-1] ? WordW'(-num_i) : WordW'(num_i);

  // Entry stage: the quotient needs more than 32 bits exactly when the
  // integer part of the magnitude reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= num_i[WordW-1];
      ovf_q[0]  <= {15'b0, mag[WordW-1:FracW]} >= den_i;
      den_q[0]  <= den_i;
      rem_q[0]  <= {15'b0, mag[WordW-1:FracW]};
      bits_q[0] <= {mag[FracW-1:0], {FracW{1'b0}}};
      quo_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [FloorW:0] trial;
    logic            take;
    assign trial = {rem_q[k-1], bits_q[k-1][WordW-1]};
    assign take  = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        den_q[k]  <= den_q[k-1];
        rem_q[k]  <= take ? FloorW'(trial - {1'b0, den_q[k-1]}) : trial[FloorW-1:0];
        bits_q[k] <= {bits_q[k-1][WordW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][WordW-2:0], take};
      end
    end
  end

  logic [WordW-1:0] q;
  assign q = quo_q[DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[DivSteps]) begin
        if (ovf_q[DivSteps] || q > 32'h8000_0000) quo_o <= 32'sh8000_0000;
        else                                       quo_o <= $signed(-q);
      end else begin
        if (ovf_q[DivSteps] || q > 32'h7FFF_FFFF) quo_o <= 32'sh7FFF_FFFF;
        else                                       quo_o <= $signed(q);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ecp_checker.sv
`default_nettype none

`include "euler_conserved_to_primitive_macros.svh"

module ecp_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire [159:0] s_axis_tdata,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [159:0] m_axis_tdata
);

  // A stalled result stays on the output unchanged.
  `ECP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // A waiting input transfer keeps its data until it is taken.
  `ECP_ASSERT(a_in_hold, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))

  // The input side is ready exactly when the output register can move.
  `ECP_ASSERT_ALWAYS(a_ready_rule, clk_i, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // A delivered density is never zero.
  `ECP_ASSERT(a_density_pos, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[30:0] != 31'd0)

  // No result is on the output when reset has just been released.
  `ECP_ASSERT(a_no_early_out, clk_i, rst_ni, $rose(rst_ni) |-> !m_axis_tvalid)

endmodule

bind euler_conserved_to_primitive ecp_checker u_ecp_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .s_axis_tdata,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);

`default_nettype wire

// File: bench/euler_conserved_to_primitive_tb.sv
`timescale 1ns / 100ps

module euler_conserved_to_primitive_tb;
  import ecp_pkg::*;

  localparam int unsigned NumRandom = 600;
  localparam int unsigned TailWait  = PipeLat + 20;
  localparam longint      CycleLimit = 400000;

  // One cell's conserved state as it travels on the input stream.
  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] mz;
    logic signed [31:0] my;
    logic signed [31:0] mx;
    logic signed [31:0] rho;
  } cons_cell_t;

  // One primitive state as it appears on the output stream, top bit first.
  typedef struct packed {
    logic               pad;
    logic               dens_err;
    logic [30:0]        pres;
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic [30:0]        rho;
  } prim_cell_t;

  // Primitive-state predictor with its own copy of the register settings,
  // and the queue of primitive states that are still owed by the block.
  class prim_scoreboard;
    logic [Gm1W-1:0]   gm1;
    logic [FloorW-1:0] rho_floor;
    logic [FloorW-1:0] p_floor;
    prim_cell_t        owed[$];
    int unsigned       errors;

    function void set_defaults();
      gm1 = Gm1Reset;
      rho_floor = DensFloorReset;
      p_floor = PresFloorReset;
      owed.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [FloorW-1:0] val);
      case (idx)
        CFG_GAMMA_M1:   gm1 = val[Gm1W-1:0];
        CFG_DENS_FLOOR: rho_floor = val;
        CFG_PRES_FLOOR: p_floor = val;
        default: ;
      endcase
    endfunction

    // Saturated Q16.16 quotient of a momentum by a positive density.
    function longint velocity(longint m, longint unsigned r);
      longint unsigned mag;
      longint unsigned q;
      mag = (m < 0) ? longint'(-m) : longint'(m);
      q = (mag << FracW) / r;
      if (m < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    function longint unsigned sq(longint v);
      longint unsigned a;
      a = (v < 0) ? longint'(-v) : longint'(v);
      return a * a;
    endfunction

    function void note_cell(cons_cell_t c);
      prim_cell_t p;
      longint unsigned r, s, ke, pg, hi, lo;
      longint vx, vy, vz, d;
      p = '0;
      if (c.rho <= 0) begin
        r = (rho_floor == 0) ? 1 : rho_floor;
        p.dens_err = 1'b1;
      end else begin
        r = longint'(c.rho);
      end
      vx = velocity(longint'(c.mx), r);
      vy = velocity(longint'(c.my), r);
      vz = velocity(longint'(c.mz), r);
      s = sq(vx) + sq(vy) + sq(vz);
      // rho * sum / 2^33, split so that no partial product overflows.
      hi = r * (s >> 32);
      lo = r * (s & 64'hFFFF_FFFF);
      ke = (hi + (lo >> 32)) >> 1;
      if (ke > (64'd1 << 40)) ke = 64'd1 << 40;
      d = longint'(c.energy) - longint'(ke);
      pg = 0;
      if (d > 0) begin
        pg = (longint'(gm1) * longint'(d)) >> FracW;
        if (pg > 64'h7FFF_FFFF) pg = 64'h7FFF_FFFF;
      end
      if (pg == 0) pg = p_floor;
      p.rho = r[30:0];
      p.vx = vx[31:0];
      p.vy = vy[31:0];
      p.vz = vz[31:0];
      p.pres = pg[30:0];
      owed.push_back(p);
    endfunction

    function void check_result(prim_cell_t got);
      prim_cell_t e;
      if (owed.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.rho != e.rho) begin
        $error("prim_density expected %0d actual %0d", e.rho, got.rho); errors++;
      end
      if (got.vx != e.vx) begin
        $error("vel_x expected %0d actual %0d", e.vx, got.vx); errors++;
      end
      if (got.vy != e.vy) begin
        $error("vel_y expected %0d actual %0d", e.vy, got.vy); errors++;
      end
      if (got.vz != e.vz) begin
        $error("vel_z expected %0d actual %0d", e.vz, got.vz); errors++;
      end
      if (got.pres != e.pres) begin
        $error("gas_pressure expected %0d actual %0d", e.pres, got.pres); errors++;
      end
      if (got.dens_err != e.dens_err) begin
        $error("density_error expected %0d actual %0d", e.dens_err, got.dens_err);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [159:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [FloorW-1:0] cfg_data_i;

  prim_scoreboard board;
  longint cycles;

  euler_conserved_to_primitive u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Whether the current phase applies idling; one random phase runs at full rate.
  logic idle_on;

  // Output side: the ready line idles at random, results are checked on the
  // rising edge and the ready line changes on the falling edge.
  initial begin
    int unsigned g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = idle_on ? gap_len() : 0;
      if (g != 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(prim_cell_t'(m_axis_tdata));
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one cell and waits for its transfer; the valid line stays high when
  // the next call follows at once, so it is never lowered and raised in a step.
  task automatic send_cell(cons_cell_t c);
    int unsigned g;
    g = idle_on ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_cell(c);
    @(negedge clk_i);
  endtask

  // Lowers valid, waits until every owed result has arrived and then waits out
  // the TailWait margin, so that the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (TailWait) @(negedge clk_i);
  endtask

  // Writes with the enable high and then waits with it low, so that back-to-back
  // calls never raise and lower the write enable at the same edge.
  task automatic write_reg(cfg_reg_e idx, logic [FloorW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0003_FFFF);
      4: return -$urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Mostly cells with a positive density, small momenta and a non-negative energy,
  // and some fully random ones.
  function automatic cons_cell_t rand_cell();
    cons_cell_t c;
    if ($urandom_range(0, 3) != 0) begin
      c.rho = $urandom_range(32'h0000_1000, 32'h0040_0000);
      c.mx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      c.my = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      c.mz = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      c.energy = $urandom_range(0, 32'h0100_0000);
    end else begin
      c.rho = rand_word();
      c.mx = rand_word();
      c.my = rand_word();
      c.mz = rand_word();
      c.energy = rand_word();
    end
    return c;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cell(rand_cell());
  endtask

  initial begin
    cons_cell_t c;
    board = new();
    board.set_defaults();
    cycles = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_GAMMA_M1;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed cells under reset settings: rest state, extremes of every
    // field, non-positive densities, saturating velocities, negative energy.
    send_cell('{energy: 32'sh0001_0000, mz: 0, my: 0, mx: 0, rho: 32'sh0001_0000});
    send_cell('{energy: 32'sh7FFF_FFFF, mz: 32'sh7FFF_FFFF, my: 32'sh8000_0000,
                mx: 32'sh7FFF_FFFF, rho: 32'sh0000_0001});
    send_cell('{energy: 32'sh8000_0000, mz: 32'sh8000_0000, my: 32'sh7FFF_FFFF,
                mx: 32'sh8000_0000, rho: 32'sh7FFF_FFFF});
    send_cell('{energy: 32'sh0010_0000, mz: 1, my: -1, mx: 32'sh0001_0000, rho: 0});
    send_cell('{energy: -1, mz: -1, my: -1, mx: -1, rho: -1});
    send_cell('{energy: 32'sh7FFF_FFFF, mz: 0, my: 0, mx: 0, rho: 32'sh8000_0000});
    send_cell('{energy: 32'sh0100_0000, mz: 0, my: 0, mx: 32'sh0002_0000,
                rho: 32'sh0001_0000});
    send_cell('{energy: 0, mz: 0, my: 0, mx: 0, rho: 32'sh0001_0000});
    send_cell('{energy: 32'sh7FFF_FFFF, mz: 0, my: 0, mx: 0, rho: 32'sh7FFF_FFFF});
    drain();

    // Zero floors and zero gamma: pressure falls back to a zero floor and a
    // density floor of zero acts as the smallest positive density.
    write_reg(CFG_GAMMA_M1, 0);
    write_reg(CFG_DENS_FLOOR, 0);
    write_reg(CFG_PRES_FLOOR, 0);
    send_cell('{energy: 32'sh0100_0000, mz: 5, my: -5, mx: 32'sh0000_0003, rho: 0});
    send_cell('{energy: 32'sh0100_0000, mz: 0, my: 0, mx: 0, rho: 32'sh0001_0000});
    drain();

    // Largest floors, and gamma with only bit 17 set.
    write_reg(CFG_GAMMA_M1, 31'd131072);
    write_reg(CFG_DENS_FLOOR, 31'h7FFF_FFFF);
    write_reg(CFG_PRES_FLOOR, 31'h7FFF_FFFF);
    send_cell('{energy: 32'sh7FFF_FFFF, mz: 0, my: 0, mx: 0, rho: 32'sh0000_1000});
    send_cell('{energy: -5, mz: 32'sh8000_0000, my: 0, mx: 32'sh7FFF_FFFF, rho: -7});
    send_cell('{energy: 0, mz: 0, my: 0, mx: 0, rho: 32'sh0001_0000});
    // Bit 17 of gamma set with other bits too.
    drain();
    write_reg(CFG_GAMMA_M1, 31'h3FFFF);
    send_cell('{energy: 32'sh7FFF_FFFF, mz: 0, my: 0, mx: 0, rho: 32'sh0001_0000});
    drain();

    // Random phases under several settings, the first under reset values.
    write_reg(CFG_GAMMA_M1, Gm1Reset);
    write_reg(CFG_DENS_FLOOR, DensFloorReset);
    write_reg(CFG_PRES_FLOOR, PresFloorReset);
    random_phase(150);
    drain();
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_GAMMA_M1, $urandom_range(1, 131072));
      write_reg(CFG_DENS_FLOOR, $urandom_range(1, 31'h7FFF_FFFF));
      write_reg(CFG_PRES_FLOOR, $urandom_range(1, 31'h7FFF_FFFF));
      idle_on = (k != 1);
      random_phase(150);
      drain();
    end
    idle_on = 1'b1;

    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ecp_pkg.sv
rtl/ecp_div.sv
rtl/euler_conserved_to_primitive.sv
rtl/ecp_checker.sv
bench/euler_conserved_to_primitive_tb.sv
